>>> rtl/hrlf_pkg.sv
`default_nettype none

package hrlf_pkg;

   // Descriptor type codes and fixed lengths
   localparam logic [7:0] TYPE_INTERFACE    = 8'h04;
   localparam logic [7:0] TYPE_HID          = 8'h21;
   localparam logic [7:0] TYPE_REPORT       = 8'h22;
   localparam logic [7:0] MIN_INTERFACE_LEN = 8'd9;
   localparam logic [7:0] HID_HEAD_LEN      = 8'd6;
   localparam logic [9:0] ENTRY_LEN         = 10'd3;

   // Byte offsets inside a descriptor
   localparam logic [7:0] OFF_LENGTH      = 8'd0;
   localparam logic [7:0] OFF_TYPE        = 8'd1;
   localparam logic [7:0] OFF_IF_NUMBER   = 8'd2;
   localparam logic [7:0] OFF_ALT_SETTING = 8'd3;
   localparam logic [7:0] OFF_NUM_ENTRIES = 8'd5;

   // Position of a byte inside a class descriptor entry
   localparam logic [1:0] SUB_TYPE = 2'd0;
   localparam logic [1:0] SUB_LOW  = 2'd1;
   localparam logic [1:0] SUB_HIGH = 2'd2;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_MALFORMED = 2'd2,
      STATUS_TOO_LARGE = 2'd3
   } scan_status_type;

   typedef enum logic {
      REG_TOTAL_LENGTH = 1'b0,
      REG_IFACE_ID     = 1'b1
   } csr_reg_type;

   // Live configuration seen by the parser
   typedef struct packed {
      logic [15:0] total_length;
      logic [7:0]  iface_id;
   } cfg_type;

   // Outcome of one processed byte
   typedef struct packed {
      logic            hit;
      logic [15:0]     report_length;
      scan_status_type scan_status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/hrlf_req_if.sv
`default_nettype none

interface hrlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       scan_start;

   modport source (output valid, output data_byte, output scan_start, input ready);
   modport sink (input valid, input data_byte, input scan_start, output ready);
endinterface

`default_nettype wire

>>> rtl/hrlf_rsp_if.sv
`default_nettype none

interface hrlf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] report_length;
   logic [1:0]  scan_status;

   modport source (output valid, output report_length, output scan_status, input ready);
   modport sink (input valid, input report_length, input scan_status, output ready);
endinterface

`default_nettype wire

>>> rtl/hrlf_csr_if.sv
`default_nettype none

interface hrlf_csr_if;
   logic        valid;
   logic        ready;
   logic        reg_index;
   logic [15:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

>>> rtl/hrlf_csr.sv
`default_nettype none

module hrlf_csr (
   input  wire logic       clock,
   input  wire logic       reset,
   hrlf_csr_if.sink        csr_ch,
   output hrlf_pkg::cfg_type cfg
);
   import hrlf_pkg::*;

   logic [15:0] total_length_ff;
   logic [15:0] total_length_in;
   logic [7:0]  iface_id_ff;
   logic [7:0]  iface_id_in;

   // Always take writes
   assign csr_ch.ready = 1'b1;

   // Decode the register index
   always_comb begin
      total_length_in = total_length_ff;
      iface_id_in     = iface_id_ff;
      if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.reg_index))
            REG_TOTAL_LENGTH: total_length_in = csr_ch.write_data;
            REG_IFACE_ID:     iface_id_in     = csr_ch.write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= '0;
         iface_id_ff     <= '0;
      end else begin
         total_length_ff <= total_length_in;
         iface_id_ff     <= iface_id_in;
      end
   end

   assign cfg.total_length = total_length_ff;
   assign cfg.iface_id     = iface_id_ff;

endmodule

`default_nettype wire

>>> rtl/hrlf_parser.sv
`default_nettype none

module hrlf_parser #(
   parameter int unsigned MAX_CONFIG_BYTES = 512
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    data_byte,
   input  wire logic          scan_start,
   input  hrlf_pkg::cfg_type  cfg,
   output hrlf_pkg::result_type result
);
   import hrlf_pkg::*;

   localparam logic [15:0] MAX_BYTES = 16'(MAX_CONFIG_BYTES);

   logic [15:0] pos_ff, pos_in, cur_pos;
   logic [7:0]  off_ff, off_in, cur_off, off_next;
   logic [7:0]  size_ff, size_in, cur_size;
   logic [7:0]  type_ff, type_in, cur_type;
   logic        sel_ff, sel_in, cur_sel;
   logic        matched_ff, matched_in, cur_matched;
   logic [7:0]  count_ff, count_in, cur_count;
   logic [7:0]  etype_ff, etype_in, cur_etype;
   logic [7:0]  elow_ff, elow_in, cur_elow;
   logic [1:0]  sub_ff, sub_in, cur_sub;
   logic        done_ff, done_in;
   logic        live;
   logic [9:0]  entries_end;

   // Start byte sees a cleared scan
   always_comb begin
      cur_pos     = scan_start ? '0 : pos_ff;
      cur_off     = scan_start ? '0 : off_ff;
      cur_size    = scan_start ? '0 : size_ff;
      cur_type    = scan_start ? '0 : type_ff;
      cur_sel     = scan_start ? 1'b0 : sel_ff;
      cur_matched = scan_start ? 1'b0 : matched_ff;
      cur_count   = scan_start ? '0 : count_ff;
      cur_etype   = scan_start ? '0 : etype_ff;
      cur_elow    = scan_start ? '0 : elow_ff;
      cur_sub     = scan_start ? '0 : sub_ff;
   end

   assign live        = scan_start || !done_ff;
   assign entries_end = 10'(HID_HEAD_LEN) + ENTRY_LEN * 10'(cur_count);

   // Walk one byte of the descriptor set
   always_comb begin
      pos_in               = cur_pos;
      off_in               = cur_off;
      off_next             = cur_off + 8'd1;
      size_in              = cur_size;
      type_in              = cur_type;
      sel_in               = cur_sel;
      matched_in           = cur_matched;
      count_in             = cur_count;
      etype_in             = cur_etype;
      elow_in              = cur_elow;
      sub_in               = cur_sub;
      done_in              = done_ff;
      result.hit           = 1'b0;
      result.report_length = '0;
      result.scan_status   = STATUS_NOT_FOUND;

      if (live) begin
         done_in = 1'b0;
         if (scan_start && cfg.total_length > MAX_BYTES) begin
            result.hit         = 1'b1;
            result.scan_status = STATUS_TOO_LARGE;
         end else if (scan_start && cfg.total_length < 16'd2) begin
            result.hit         = 1'b1;
            result.scan_status = STATUS_NOT_FOUND;
         end else begin
            if (cur_off == OFF_LENGTH) begin
               size_in = data_byte;
               if (data_byte < 8'd2 ||
                   17'(cur_pos) + 17'(data_byte) > 17'(cfg.total_length)) begin
                  result.hit         = 1'b1;
                  result.scan_status = STATUS_MALFORMED;
               end
            end else if (cur_off == OFF_TYPE) begin
               type_in = data_byte;
               if ((data_byte == TYPE_INTERFACE && cur_size < MIN_INTERFACE_LEN) ||
                   (data_byte == TYPE_HID && cur_sel && cur_size < HID_HEAD_LEN)) begin
                  result.hit         = 1'b1;
                  result.scan_status = STATUS_MALFORMED;
               end
            end else if (cur_type == TYPE_INTERFACE) begin
               if (cur_off == OFF_IF_NUMBER) begin
                  matched_in = (data_byte == cfg.iface_id);
               end else if (cur_off == OFF_ALT_SETTING) begin
                  sel_in = cur_matched && data_byte == 8'd0;
               end
            end else if (cur_type == TYPE_HID && cur_sel) begin
               if (cur_off == OFF_NUM_ENTRIES) begin
                  count_in = data_byte;
                  sub_in   = SUB_TYPE;
                  if (10'(HID_HEAD_LEN) + ENTRY_LEN * 10'(data_byte) > 10'(cur_size)) begin
                     result.hit         = 1'b1;
                     result.scan_status = STATUS_MALFORMED;
                  end
               end else if (cur_off >= HID_HEAD_LEN) begin
                  // Track the byte's place inside its 3-byte entry
                  sub_in = (cur_sub == SUB_HIGH) ? SUB_TYPE : cur_sub + 2'd1;
                  if (10'(cur_off) < entries_end) begin
                     case (cur_sub)
                        SUB_TYPE: etype_in = data_byte;
                        SUB_LOW:  elow_in  = data_byte;
                        SUB_HIGH: begin
                           if (cur_etype == TYPE_REPORT) begin
                              result.hit           = 1'b1;
                              result.report_length = {data_byte, cur_elow};
                              result.scan_status   = STATUS_FOUND;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end

            // Advance position; close the descriptor at its last byte
            if (!result.hit) begin
               pos_in = cur_pos + 16'd1;
               off_in = off_next;
               if (off_next >= size_in) begin
                  off_in = '0;
                  if (17'(pos_in) + 17'd2 > 17'(cfg.total_length)) begin
                     result.hit         = 1'b1;
                     result.scan_status = STATUS_NOT_FOUND;
                  end
               end
            end
         end
         if (result.hit) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         off_ff     <= '0;
         size_ff    <= '0;
         type_ff    <= '0;
         sel_ff     <= 1'b0;
         matched_ff <= 1'b0;
         count_ff   <= '0;
         etype_ff   <= '0;
         elow_ff    <= '0;
         sub_ff     <= '0;
         done_ff    <= 1'b1;
      end else if (step) begin
         pos_ff     <= pos_in;
         off_ff     <= off_in;
         size_ff    <= size_in;
         type_ff    <= type_in;
         sel_ff     <= sel_in;
         matched_ff <= matched_in;
         count_ff   <= count_in;
         etype_ff   <= etype_in;
         elow_ff    <= elow_in;
         sub_ff     <= sub_in;
         done_ff    <= done_in;
      end
   end

`ifndef SYNTHESIS
   a_hit_only_live: assert property (@(posedge clock) disable iff (reset)
      result.hit |-> live)
      else $error("result raised while no scan is running");

   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      step && result.hit |=> done_ff)
      else $error("scan still running after its result");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> (off_ff == 8'd0 || off_ff < size_ff))
      else $error("descriptor offset past descriptor length");
`endif

endmodule

`default_nettype wire

>>> rtl/hid_report_length_finder.sv
`default_nettype none

// A request passes the input register, then its result the result register, to rsp.
// Throughput: one request per cycle while the result register has room;
// one byte walk of short compare logic per cycle.
// Reset: synchronous, active high; the valid flags clear and the scan is idle
// until a request with scan_start arrives.
module hid_report_length_finder #(
   parameter int unsigned MAX_CONFIG_BYTES = 512
) (
   input wire logic  clock,
   input wire logic  reset,
   hrlf_req_if.sink  req_ch,
   hrlf_rsp_if.source rsp_ch,
   hrlf_csr_if.sink  csr_ch
);
   import hrlf_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        advance;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_length_ff;
   logic [1:0]  rsp_status_ff;

   hrlf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   hrlf_parser #(
      .MAX_CONFIG_BYTES (MAX_CONFIG_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .scan_start (in_start_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Process the held request once the result register has room
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.data_byte;
         in_start_ff <= req_ch.scan_start;
      end
   end

   // Result register: load on a hit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (advance && result.hit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.hit) begin
         rsp_length_ff <= result.report_length;
         rsp_status_ff <= result.scan_status;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.report_length = rsp_length_ff;
   assign rsp_ch.scan_status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_hit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && result.hit |=> rsp_valid_ff)
      else $error("hit did not load the result register");

   a_stalled_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("stalled request lost from the input register");

   a_length_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_FOUND |-> rsp_length_ff == 16'd0)
      else $error("nonzero length on a result other than found");
`endif

endmodule

`default_nettype wire

>>> dv/hid_report_length_finder_test.sv
`default_nettype none

module hid_report_length_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hrlf_pkg::*;

   localparam int unsigned MAX_BYTES     = 512;
   localparam int unsigned LATENCY       = 2;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned IDLING_ITEMS  = 850;
   localparam int unsigned STREAM_ITEMS  = 250;

   // Descriptor types and lengths used only to build stimulus
   localparam logic [7:0] TYPE_CONFIG   = 8'h02;
   localparam logic [7:0] TYPE_ENDPOINT = 8'h05;
   localparam logic [7:0] TYPE_PHYSICAL = 8'h23;
   localparam logic [7:0] CONFIG_LEN    = 8'd9;
   localparam logic [7:0] ENDPOINT_LEN  = 8'd7;

   typedef struct packed {
      logic [15:0]     report_length;
      scan_status_type scan_status;
   } scan_outcome_type;

   logic clock;
   logic reset;

   hrlf_req_if req_ch();
   hrlf_rsp_if rsp_ch();
   hrlf_csr_if csr_ch();

   hid_report_length_finder #(
      .MAX_CONFIG_BYTES(MAX_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Configuration as the block should see it
   logic [15:0] cfg_total_length = '0;
   logic [7:0]  cfg_interface    = '0;

   // Descriptor walk state
   logic [15:0] walk_pos    = '0;
   logic [7:0]  desc_off    = '0;
   logic [7:0]  desc_len    = '0;
   logic [7:0]  desc_kind   = '0;
   bit          iface_hit   = 1'b0;
   bit          number_hit  = 1'b0;
   logic [7:0]  entry_total = '0;
   logic [7:0]  entry_kind  = '0;
   logic [7:0]  entry_lsb   = '0;
   bit          walk_idle   = 1'b1;

   scan_outcome_type pending_outcomes[$];
   scan_outcome_type oldest_outcome;
   logic [7:0]       set_bytes[$];

   int unsigned error_count    = 0;
   int unsigned consumed_items = 0;
   int unsigned quiet_cycles   = 0;
   int          rsp_stall_left = 0;
   int unsigned req_idle_pct   = 0;
   int unsigned rsp_idle_pct   = 0;
   bit          idle_enabled   = 1'b0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the walk with one outcome
   function automatic bit close_scan(input logic [15:0] length, input scan_status_type status,
                                     output scan_outcome_type outcome);
      outcome.report_length = length;
      outcome.scan_status   = status;
      walk_idle = 1'b1;
      return 1'b1;
   endfunction

   // Advance the descriptor walk by one byte; returns 1 when the scan is decided
   function automatic bit advance_walk(input logic [7:0] b, input bit start,
                                       output scan_outcome_type outcome);
      logic [7:0]  off;
      int unsigned rel;
      outcome = '0;
      if (start) begin
         walk_pos    = '0;
         desc_off    = '0;
         desc_len    = '0;
         desc_kind   = '0;
         iface_hit   = 1'b0;
         number_hit  = 1'b0;
         entry_total = '0;
         entry_kind  = '0;
         entry_lsb   = '0;
         walk_idle   = 1'b0;
         if (cfg_total_length > MAX_BYTES)
            return close_scan('0, STATUS_TOO_LARGE, outcome);
         if (cfg_total_length < 16'd2)
            return close_scan('0, STATUS_NOT_FOUND, outcome);
      end else if (walk_idle) begin
         return 1'b0;
      end

      off = desc_off;
      if (off == OFF_LENGTH) begin
         desc_len = b;
         if (b < 8'd2 || 32'(walk_pos) + 32'(b) > 32'(cfg_total_length))
            return close_scan('0, STATUS_MALFORMED, outcome);
      end else if (off == OFF_TYPE) begin
         desc_kind = b;
         if (b == TYPE_INTERFACE && desc_len < MIN_INTERFACE_LEN)
            return close_scan('0, STATUS_MALFORMED, outcome);
         if (b == TYPE_HID && iface_hit && desc_len < HID_HEAD_LEN)
            return close_scan('0, STATUS_MALFORMED, outcome);
      end else if (desc_kind == TYPE_INTERFACE) begin
         if (off == OFF_IF_NUMBER)
            number_hit = (b == cfg_interface);
         else if (off == OFF_ALT_SETTING)
            iface_hit = number_hit && (b == 8'd0);
      end else if (desc_kind == TYPE_HID && iface_hit) begin
         if (off == OFF_NUM_ENTRIES) begin
            entry_total = b;
            if (32'(HID_HEAD_LEN) + 32'(ENTRY_LEN) * 32'(b) > 32'(desc_len))
               return close_scan('0, STATUS_MALFORMED, outcome);
         end else if (off >= HID_HEAD_LEN) begin
            rel = 32'(off - HID_HEAD_LEN);
            if (rel / 32'(ENTRY_LEN) < 32'(entry_total)) begin
               if (rel % 32'(ENTRY_LEN) == 32'(SUB_TYPE))
                  entry_kind = b;
               else if (rel % 32'(ENTRY_LEN) == 32'(SUB_LOW))
                  entry_lsb = b;
               else if (entry_kind == TYPE_REPORT)
                  return close_scan({b, entry_lsb}, STATUS_FOUND, outcome);
            end
         end
      end

      walk_pos = walk_pos + 16'd1;
      desc_off = off + 8'd1;
      if (desc_off >= desc_len) begin
         desc_off = '0;
         if (32'(walk_pos) + 32'd2 > 32'(cfg_total_length))
            return close_scan('0, STATUS_NOT_FOUND, outcome);
      end
      return 1'b0;
   endfunction

   // Send one request, with an optional idle burst ahead of it
   task automatic send_request(input logic [7:0] data, input bit start);
      int unsigned      gap;
      scan_outcome_type outcome;
      gap = 0;
      if (idle_enabled && $urandom_range(0, 99) < req_idle_pct)
         gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= data;
      req_ch.scan_start <= start;
      do @(posedge clock); while (!req_ch.ready);
      if (advance_walk(data, start, outcome))
         pending_outcomes.push_back(outcome);
      consumed_items++;
   endtask

   // Write one configuration register
   task automatic write_register(input csr_reg_type index, input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.reg_index  <= index;
      csr_ch.write_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == REG_TOTAL_LENGTH)
         cfg_total_length = value;
      else
         cfg_interface = value[7:0];
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected result, then let the pipeline empty
   task automatic drain_and_pause();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Send the first bytes of the current set; unless noisy, stop shortly after the scan decides
   task automatic play_set(input int unsigned length, input bit noisy);
      int unsigned i;
      int unsigned extras;
      bit          start;
      extras = $urandom_range(0, 3);
      for (i = 0; i < length; i++) begin
         start = (i == 0) || (noisy && $urandom_range(0, 15) == 0);
         send_request(set_bytes[i], start);
         if (walk_idle && !noisy) begin
            if (extras == 0)
               break;
            extras--;
         end
      end
   endtask

   // Build a plausible configuration descriptor set around one interface number
   task automatic build_descriptor_set(input logic [7:0] target);
      int unsigned len;
      int unsigned n;
      int unsigned claim;
      logic [7:0]  kind;
      set_bytes.delete();
      set_bytes.push_back(CONFIG_LEN);
      set_bytes.push_back(TYPE_CONFIG);
      repeat (7) set_bytes.push_back(8'($urandom));
      repeat ($urandom_range(1, 3)) begin
         // interface descriptor, sometimes with trailing bytes
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : 9;
         set_bytes.push_back(8'(len));
         set_bytes.push_back(TYPE_INTERFACE);
         set_bytes.push_back(($urandom_range(0, 2) != 0) ? target : 8'($urandom));
         set_bytes.push_back(($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom));
         repeat (len - 4) set_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) begin
               // HID descriptor too short for its head
               len = $urandom_range(2, 5);
               set_bytes.push_back(8'(len));
               set_bytes.push_back(TYPE_HID);
               repeat (len - 2) set_bytes.push_back(8'($urandom));
            end else begin
               len = 6 + 3 * n + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
               claim = ($urandom_range(0, 9) == 0) ? n + 1 : n;
               set_bytes.push_back(8'(len));
               set_bytes.push_back(TYPE_HID);
               repeat (3) set_bytes.push_back(8'($urandom));
               set_bytes.push_back(8'(claim));
               repeat (n) begin
                  case ($urandom_range(0, 3))
                     0, 1: kind = TYPE_REPORT;
                     2: kind = TYPE_PHYSICAL;
                     default: kind = 8'($urandom);
                  endcase
                  set_bytes.push_back(kind);
                  set_bytes.push_back(8'($urandom));
                  set_bytes.push_back(8'($urandom));
               end
               repeat (len - 6 - 3 * n) set_bytes.push_back(8'($urandom));
            end
         end
         repeat ($urandom_range(0, 2)) begin
            set_bytes.push_back(ENDPOINT_LEN);
            set_bytes.push_back(TYPE_ENDPOINT);
            repeat (5) set_bytes.push_back(8'($urandom));
         end
      end
      // corrupt one byte now and then
      if ($urandom_range(0, 4) == 0)
         set_bytes[$urandom_range(0, set_bytes.size() - 1)] =
            $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 9));
   endtask

   // Pick a set and a configuration, write what changed, then stream the set
   task automatic run_descriptor_set();
      int unsigned size;
      int unsigned pick;
      logic [7:0]  target;
      logic [15:0] total;
      bit          noisy;
      noisy = ($urandom_range(0, 9) == 0);
      pick  = $urandom_range(0, 3);
      target = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      if ($urandom_range(0, 1))
         target = cfg_interface;
      if (noisy) begin
         set_bytes.delete();
         repeat ($urandom_range(4, 40)) set_bytes.push_back(8'($urandom));
      end else begin
         build_descriptor_set(target);
      end
      size = set_bytes.size();
      case ($urandom_range(0, 9))
         0: total = 16'((size > 8) ? size - $urandom_range(1, 8) : size - 1);
         1: total = 16'(size + $urandom_range(1, 4));
         2: total = $urandom_range(0, 1) ? 16'($urandom_range(0, 1))
                                         : 16'($urandom_range(MAX_BYTES + 1, 65535));
         default: total = 16'(size);
      endcase
      req_idle_pct = 10 * $urandom_range(0, 3);
      rsp_idle_pct = 10 * $urandom_range(0, 3);

      if (total != cfg_total_length || target != cfg_interface) begin
         drain_and_pause();
         if (total != cfg_total_length || $urandom_range(0, 3) == 0)
            write_register(REG_TOTAL_LENGTH, total);
         if (target != cfg_interface)
            write_register(REG_IFACE_ID, {8'($urandom), target});
      end
      // a broken prefix first, restarted by the full set
      if (!noisy && $urandom_range(0, 7) == 0)
         play_set($urandom_range(1, size - 1), 1'b0);
      play_set(size, noisy);
      // stray bytes with no start
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) send_request(8'($urandom), 1'b0);
   endtask

   task automatic test_directed_cases();
      idle_enabled = 1'b1;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      // total length just over the maximum, then a byte to ignore
      write_register(REG_TOTAL_LENGTH, 16'(MAX_BYTES + 1));
      write_register(REG_IFACE_ID, 16'hFFFF);
      send_request(CONFIG_LEN, 1'b1);
      send_request(8'hFF, 1'b0);
      // largest total length
      drain_and_pause();
      write_register(REG_TOTAL_LENGTH, 16'hFFFF);
      send_request(CONFIG_LEN, 1'b1);
      // empty set
      drain_and_pause();
      write_register(REG_TOTAL_LENGTH, 16'd0);
      send_request(CONFIG_LEN, 1'b1);
      // length byte below two
      drain_and_pause();
      write_register(REG_TOTAL_LENGTH, 16'd2);
      send_request(8'd1, 1'b1);
      // interface descriptor too short
      drain_and_pause();
      write_register(REG_TOTAL_LENGTH, 16'(MAX_BYTES));
      send_request(8'd8, 1'b1);
      send_request(TYPE_INTERFACE, 1'b0);
      // report entry found with the largest length
      drain_and_pause();
      write_register(REG_TOTAL_LENGTH, 16'd18);
      set_bytes = '{8'd9, TYPE_INTERFACE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'd9, TYPE_HID, 8'h11, 8'h01, 8'h00, 8'h01, TYPE_REPORT, 8'hFF, 8'hFF};
      play_set(set_bytes.size(), 1'b0);
   endtask

   task automatic test_random_sets();
      int unsigned first_items;
      idle_enabled = 1'b1;
      first_items  = consumed_items;
      while (consumed_items - first_items < IDLING_ITEMS)
         run_descriptor_set();
   endtask

   task automatic test_streaming_sets();
      int unsigned first_items;
      idle_enabled = 1'b0;
      first_items  = consumed_items;
      while (consumed_items - first_items < STREAM_ITEMS)
         run_descriptor_set();
   endtask

   // Drive the result channel's ready with random stall bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall_left = $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual length %h status %0d",
                     $time, rsp_ch.report_length, rsp_ch.scan_status);
            error_count++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_ch.report_length !== oldest_outcome.report_length) begin
               $display("%0t: report_length mismatch, expected %h actual %h",
                        $time, oldest_outcome.report_length, rsp_ch.report_length);
               error_count++;
            end
            if (rsp_ch.scan_status !== oldest_outcome.scan_status) begin
               $display("%0t: scan_status mismatch, expected %0d actual %0d",
                        $time, oldest_outcome.scan_status, rsp_ch.scan_status);
               error_count++;
            end
         end
      end
   end

   // Give up when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.scan_start = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.reg_index  = REG_TOTAL_LENGTH;
      csr_ch.write_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_sets();
      test_streaming_sets();

      drain_and_pause();
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
